// ----- design/qst_pkg.sv -----
// qst_pkg: shared constants and types for the quintic swing trajectory block.
// No dependencies; imported by every module of the block.
`default_nettype none
package qst_pkg;

    localparam int unsigned ONE_Q15    = 32768;
    localparam int unsigned APEX_LO    = 9830;
    localparam int unsigned APEX_HI    = 22938;
    localparam int unsigned XFER_LO    = 11469;
    localparam int unsigned XFER_HI    = 21299;
    localparam int unsigned PH_020     = 6554;
    localparam int unsigned PH_025     = 8192;
    localparam int unsigned PH_080     = 26214;

    localparam int unsigned DIV_STAGES = 5;
    localparam int unsigned DIV_BITS   = 3;
    localparam int unsigned QUIN_STAGES = 4;
    localparam int unsigned MID_STAGES = DIV_STAGES + QUIN_STAGES;

    typedef enum logic [1:0] {
        REG_CLEARANCE = 2'd0,
        REG_APEX      = 2'd1,
        REG_TRANSFER  = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic signed [23:0] sx;
        logic signed [23:0] sy;
        logic signed [23:0] sz;
        logic signed [24:0] dx;
        logic signed [24:0] dy;
        logic signed [25:0] dzu;
        logic signed [25:0] dzd;
    } payload_t;

endpackage
`default_nettype wire

// ----- design/qst_div.sv -----
// qst_div: pipelined restoring divider, saturating Q1.15 quotient of num*2^15/den.
// Depends on qst_pkg for stage count and bits per stage.
`default_nettype none
module qst_div (
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic [15:0] num,
    input  wire logic [14:0] den,
    output logic      [15:0] quo
);
    import qst_pkg::*;

    localparam int unsigned QB = DIV_STAGES * DIV_BITS;

    logic [14:0]   rem_reg [DIV_STAGES];
    logic [QB-1:0] q_reg   [DIV_STAGES];
    logic [14:0]   den_reg [DIV_STAGES];
    logic          sat_reg [DIV_STAGES];

    logic [14:0]   rem_next [DIV_STAGES];
    logic [QB-1:0] q_next   [DIV_STAGES];
    logic [14:0]   den_next [DIV_STAGES];
    logic          sat_next [DIV_STAGES];

    always_comb begin
        logic [15:0] r;
        logic [14:0] d;
        logic [QB-1:0] q;
        for (int i = 0; i < DIV_STAGES; i++) begin
            if (i == 0) begin
                r = {1'b0, num[14:0]};
                d = den;
                q = '0;
                sat_next[i] = (num >= {1'b0, den});
            end else begin
                r = {1'b0, rem_reg[i-1]};
                d = den_reg[i-1];
                q = q_reg[i-1];
                sat_next[i] = sat_reg[i-1];
            end
            for (int b = 0; b < DIV_BITS; b++) begin
                r = {r[14:0], 1'b0};
                q = {q[QB-2:0], 1'b0};
                if (r >= {1'b0, d}) begin
                    r = r - {1'b0, d};
                    q[0] = 1'b1;
                end
            end
            rem_next[i] = r[14:0];
            q_next[i]   = q;
            den_next[i] = d;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < DIV_STAGES; i++) begin
                rem_reg[i] <= rem_next[i];
                q_reg[i]   <= q_next[i];
                den_reg[i] <= den_next[i];
                sat_reg[i] <= sat_next[i];
            end
        end
    end

    assign quo = sat_reg[DIV_STAGES-1] ? 16'(ONE_Q15)
                                       : {1'b0, q_reg[DIV_STAGES-1][14:0]};

endmodule
`default_nettype wire

// ----- design/qst_quintic.sv -----
// qst_quintic: four-stage pipelined quintic smoothstep s = t^3 (10 - 15t + 6t^2), Q1.15.
// Depends on qst_pkg for constants.
`default_nettype none
module qst_quintic (
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire logic [15:0] t,
    output logic      [15:0] s
);
    import qst_pkg::*;

    logic [15:0] t1_reg;
    logic [30:0] t2_reg;
    logic [45:0] t3_reg;
    logic [35:0] p_reg;
    logic [51:0] cp_reg;
    logic [15:0] s_reg;

    logic [15:0] c;
    logic [35:0] p_next;
    logic [51:0] r_next;

    always_comb begin
        p_next = 36'(t2_reg) * 36'd6 + (36'd10 << 30) - 36'(t1_reg) * 36'd491520;
        c      = 16'((t3_reg + (46'd1 << 29)) >> 30);
        r_next = (cp_reg + (52'd1 << 29)) >> 30;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t1_reg <= t;
            t2_reg <= 31'(32'(t) * 32'(t));
            t3_reg <= 46'(t2_reg) * 46'(t1_reg);
            p_reg  <= p_next;
            cp_reg <= 52'(c) * 52'(p_reg);
            s_reg  <= (r_next > 52'(ONE_Q15)) ? 16'(ONE_Q15) : r_next[15:0];
        end
    end

    assign s = s_reg;

endmodule
`default_nettype wire

// ----- design/quintic_swing_trajectory.sv -----
// quintic_swing_trajectory: top level, front stage, delay lines, weighting and output.
// Depends on qst_pkg, qst_div and qst_quintic.
//
// One item enters every cycle while the output is not stalled. The pipeline has
// twelve register stages: front stage, five
// divider stages at three quotient bits each, four quintic stages, product stage
// and output register. The whole pipeline moves together: it advances whenever
// the output register is empty or its transfer completes, so a stall holds every
// stage in place.
`default_nettype none
module quintic_swing_trajectory (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_wr_en,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [16:0]  cfg_data,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // progress[15:0], start_x, start_y, start_z, end_x, end_y, end_z (24 each)
    input  wire logic [159:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // foot_x[23:0], foot_y[47:24], foot_z[71:48]
    output logic      [71:0]  m_tdata
);
    import qst_pkg::*;

    logic [16:0] clearance_reg;
    logic [15:0] apex_reg;
    logic [15:0] xfer_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearance_reg <= 17'd3277;
            apex_reg      <= 16'd16384;
            xfer_reg      <= 16'd16384;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_CLEARANCE: clearance_reg <= cfg_data;
                REG_APEX:      apex_reg      <= cfg_data[15:0];
                REG_TRANSFER:  xfer_reg      <= cfg_data[15:0];
                default:       ;
            endcase
        end
    end

    logic adv;
    logic m_valid_reg;
    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;

    // front stage
    logic [15:0] prog;
    logic signed [23:0] sx, sy, sz, ex, ey, ez;
    logic [15:0] apex, xfer;
    logic signed [17:0] n, h;
    logic signed [25:0] top;
    logic [15:0] xyt_next;
    payload_t pl_next;

    always_comb begin
        prog = s_tdata[15:0];
        sx = $signed(s_tdata[39:16]);
        sy = $signed(s_tdata[63:40]);
        sz = $signed(s_tdata[87:64]);
        ex = $signed(s_tdata[111:88]);
        ey = $signed(s_tdata[135:112]);
        ez = $signed(s_tdata[159:136]);
        apex = (apex_reg < 16'(APEX_LO)) ? 16'(APEX_LO) :
               (apex_reg > 16'(APEX_HI)) ? 16'(APEX_HI) : apex_reg;
        xfer = (xfer_reg < 16'(XFER_LO)) ? 16'(XFER_LO) :
               (xfer_reg > 16'(XFER_HI)) ? 16'(XFER_HI) : xfer_reg;
        n = $signed({2'b0, prog}) - $signed({2'b0, apex}) - 18'sd6554;
        h = ($signed({2'b0, prog}) - $signed({2'b0, xfer}) + 18'sd8192) <<< 1;
        if (h < 0) xyt_next = '0;
        else if (h > 18'sd32768) xyt_next = 16'(ONE_Q15);
        else xyt_next = h[15:0];
        top = ((sz > ez) ? 26'(sz) : 26'(ez)) + $signed({9'b0, clearance_reg});
        pl_next.sx  = sx;
        pl_next.sy  = sy;
        pl_next.sz  = sz;
        pl_next.dx  = 25'(ex) - 25'(sx);
        pl_next.dy  = 25'(ey) - 25'(sy);
        pl_next.dzu = top - 26'(sz);
        pl_next.dzd = 26'(ez) - top;
    end

    logic        v0_reg;
    logic [15:0] num1_reg, num2_reg, xyt0_reg;
    logic [14:0] den1_reg, den2_reg;
    payload_t    pl0_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            num1_reg <= prog;
            num2_reg <= (n > 0) ? n[15:0] : 16'd0;
            den1_reg <= 15'(apex - 16'(PH_020));
            den2_reg <= 15'(16'(PH_080) - apex);
            xyt0_reg <= xyt_next;
            pl0_reg  <= pl_next;
        end
    end

    // dividers and quintics
    logic [15:0] up_t, dn_t, s_xy, s_up, s_dn;
    logic [15:0] xyt_pipe_reg [DIV_STAGES];

    qst_div u_div_up (.aclk(aclk), .en(adv), .num(num1_reg), .den(den1_reg), .quo(up_t));
    qst_div u_div_dn (.aclk(aclk), .en(adv), .num(num2_reg), .den(den2_reg), .quo(dn_t));

    qst_quintic u_q_xy (.aclk(aclk), .en(adv), .t(xyt_pipe_reg[DIV_STAGES-1]), .s(s_xy));
    qst_quintic u_q_up (.aclk(aclk), .en(adv), .t(up_t), .s(s_up));
    qst_quintic u_q_dn (.aclk(aclk), .en(adv), .t(dn_t), .s(s_dn));

    logic     vpipe_reg  [MID_STAGES];
    payload_t plpipe_reg [MID_STAGES];

    always_ff @(posedge aclk) begin
        if (adv) begin
            xyt_pipe_reg[0] <= xyt0_reg;
            for (int i = 1; i < DIV_STAGES; i++) xyt_pipe_reg[i] <= xyt_pipe_reg[i-1];
            plpipe_reg[0] <= pl0_reg;
            for (int i = 1; i < MID_STAGES; i++) plpipe_reg[i] <= plpipe_reg[i-1];
        end
    end

    // products
    logic w_valid_reg;
    logic signed [41:0] px_reg, py_reg;
    logic signed [42:0] pu_reg, pd_reg;
    logic signed [23:0] wsx_reg, wsy_reg, wsz_reg;
    payload_t pl_last;
    assign pl_last = plpipe_reg[MID_STAGES-1];

    always_ff @(posedge aclk) begin
        if (adv) begin
            px_reg  <= 42'($signed({1'b0, s_xy})) * 42'($signed(pl_last.dx));
            py_reg  <= 42'($signed({1'b0, s_xy})) * 42'($signed(pl_last.dy));
            pu_reg  <= 43'($signed({1'b0, s_up})) * 43'($signed(pl_last.dzu));
            pd_reg  <= 43'($signed({1'b0, s_dn})) * 43'($signed(pl_last.dzd));
            wsx_reg <= pl_last.sx;
            wsy_reg <= pl_last.sy;
            wsz_reg <= pl_last.sz;
        end
    end

    logic signed [27:0] fx, fy, fz;
    logic [23:0] fx_sat, fy_sat, fz_sat;

    function automatic logic [23:0] sat24(input logic signed [27:0] v);
        if (v > 28'sd8388607) return 24'h7FFFFF;
        if (v < -28'sd8388608) return 24'h800000;
        return v[23:0];
    endfunction

    always_comb begin
        fx = 28'(wsx_reg) + 28'((px_reg + 42'sd16384) >>> 15);
        fy = 28'(wsy_reg) + 28'((py_reg + 42'sd16384) >>> 15);
        fz = 28'(wsz_reg) + 28'((pu_reg + 43'sd16384) >>> 15)
                          + 28'((pd_reg + 43'sd16384) >>> 15);
        fx_sat = sat24(fx);
        fy_sat = sat24(fy);
        fz_sat = sat24(fz);
    end

    logic [71:0] m_data_reg;

    always_ff @(posedge aclk) begin
        if (adv) m_data_reg <= {fz_sat, fy_sat, fx_sat};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg      <= 1'b0;
            w_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < MID_STAGES; i++) vpipe_reg[i] <= 1'b0;
        end else if (adv) begin
            v0_reg       <= s_tvalid;
            vpipe_reg[0] <= v0_reg;
            for (int i = 1; i < MID_STAGES; i++) vpipe_reg[i] <= vpipe_reg[i-1];
            w_valid_reg  <= vpipe_reg[MID_STAGES-1];
            m_valid_reg  <= w_valid_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_den_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v0_reg |-> (den1_reg >= 15'd3276 && den1_reg <= 15'd16384 &&
                    den2_reg >= 15'd3276 && den2_reg <= 15'd16384))
        else $error("phase span out of range");

    a_div_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        vpipe_reg[DIV_STAGES-1] |-> (up_t <= 16'(ONE_Q15) && dn_t <= 16'(ONE_Q15)))
        else $error("divider quotient above one");

    a_quin_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        vpipe_reg[MID_STAGES-1] |->
            (s_xy <= 16'(ONE_Q15) && s_up <= 16'(ONE_Q15) && s_dn <= 16'(ONE_Q15)))
        else $error("smoothstep above one");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> ($stable(w_valid_reg) && $stable(px_reg) && $stable(vpipe_reg[0])))
        else $error("pipeline moved during stall");

endmodule
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// testbench: checks quintic_swing_trajectory foot positions against a local predictor.
// Depends on qst_pkg and the design; random stalls on both stream sides.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import qst_pkg::*;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [1:0]   cfg_index = '0;
    logic [16:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [159:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [71:0]  m_tdata;

    quintic_swing_trajectory u_top (.*);

    always #10 aclk = ~aclk;

    longint   clr_q = 3277, apex_q = 16384, xfer_q = 16384;
    logic [71:0] foot_q[$];
    int       errors = 0;
    bit       calm = 1'b0;
    int       idle_cycles = 0;

    function automatic longint smooth5(longint t);
        longint c, p, s;
        if (t < 0) t = 0;
        if (t > 32768) t = 32768;
        c = (t * t * t + (64'sd1 <<< 29)) >>> 30;
        p = 6 * t * t - 15 * 32768 * t + 10 * (64'sd1 <<< 30);
        s = (c * p + (64'sd1 <<< 29)) >>> 30;
        return s > 32768 ? 32768 : s;
    endfunction

    function automatic longint scale(longint s, longint d);
        return (s * d + 16384) >>> 15;
    endfunction

    function automatic logic [23:0] sat24(longint v);
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        return v[23:0];
    endfunction

    function automatic logic [71:0] foot_of(logic [159:0] d);
        longint p, sx, sy, sz, ex, ey, ez, ap, xf, xy, up, dn, n, top;
        p  = d[15:0];
        sx = signed'(d[39:16]);  sy = signed'(d[63:40]);  sz = signed'(d[87:64]);
        ex = signed'(d[111:88]); ey = signed'(d[135:112]); ez = signed'(d[159:136]);
        ap = apex_q < 9830 ? 9830 : (apex_q > 22938 ? 22938 : apex_q);
        xf = xfer_q < 11469 ? 11469 : (xfer_q > 21299 ? 21299 : xfer_q);
        xy = smooth5(2 * (p - xf + 8192));
        up = smooth5((p * 32768) / (ap - 6554));
        n  = p - ap - 6554;
        dn = n <= 0 ? 0 : smooth5((n * 32768) / (26214 - ap));
        top = (sz > ez ? sz : ez) + clr_q;
        return {sat24(sz + scale(up, top - sz) + scale(dn, ez - top)),
                sat24(sy + scale(xy, ey - sy)), sat24(sx + scale(xy, ex - sx))};
    endfunction

    // sink side
    int rdy_hold = 0;
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (foot_q.size() == 0) begin
                errors++;
                $display("%0t unexpected transfer: expected none actual %h", $time, m_tdata);
            end else begin
                logic [71:0] e;
                e = foot_q.pop_front();
                for (int k = 0; k < 3; k++)
                    if (e[24*k +: 24] != m_tdata[24*k +: 24]) begin
                        errors++;
                        $display("%0t foot field %0d: expected %h actual %h",
                                 $time, k, e[24*k +: 24], m_tdata[24*k +: 24]);
                    end
            end
        end
        if (calm) m_tready <= 1'b1;
        else if (rdy_hold > 0) rdy_hold--;
        else begin
            m_tready <= $urandom_range(0, 1);
            rdy_hold = $urandom_range(1, 17);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles > 2000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // tvalid stays high between back-to-back transfers; drain() drops it
    task automatic send_item(logic [159:0] d);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        foot_q.push_back(foot_of(d));
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (foot_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [16:0] v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1; cfg_index <= idx; cfg_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_CLEARANCE: clr_q = v;
            REG_APEX:      apex_q = v[15:0];
            REG_TRANSFER:  xfer_q = v[15:0];
            default: ;
        endcase
    endtask

    function automatic logic [23:0] rpos();
        case ($urandom_range(0, 3))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($urandom_range(0, 262143) - 131072);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [159:0] rand_item();
        logic [15:0] p;
        p = $urandom_range(0, 9) == 0 ? 16'($urandom) : 16'($urandom_range(0, 32768));
        return {rpos(), rpos(), rpos(), rpos(), rpos(), rpos(), p};
    endfunction

    task automatic test_directed();
        logic [15:0] pv[8] = '{0, 1, 6554, 16384, 22938, 32767, 32768, 16'hFFFF};
        foreach (pv[i]) send_item({24'h7FFFFF, 24'h800000, 24'h000000,
                                   24'h800000, 24'h7FFFFF, 24'h000100, pv[i]});
        for (int i = 0; i < 8; i++) send_item(rand_item());
        drain();
    endtask

    task automatic test_config(logic [16:0] c, logic [15:0] a, logic [15:0] t, int cnt);
        write_reg(REG_CLEARANCE, c);
        write_reg(REG_APEX, a);
        write_reg(REG_TRANSFER, t);
        write_reg(cfg_index_t'(2'd3), 17'h1FFFF);
        repeat (cnt) send_item(rand_item());
        drain();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_config(17'd0, 16'd0, 16'd0, 100);
        test_config(17'd65536, 16'd32768, 16'd32768, 100);
        test_config(17'h1FFFF, 16'hFFFF, 16'hFFFF, 80);
        test_config(17'd3277, 16'd9830, 16'd21299, 100);
        test_config(17'($urandom), 16'($urandom_range(0, 32768)),
                    16'($urandom_range(0, 32768)), 150);
        calm = 1'b1;
        test_config(17'd1000, 16'd22938, 16'd11469, 150);
        if (errors == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire
